[hdl/lcdns_pkg.sv]
package lcdns_pkg;

	typedef enum logic [1:0] {
		OP_CMD    = 2'd0,
		OP_DATA   = 2'd1,
		OP_CURSOR = 2'd2,
		OP_INIT   = 2'd3
	} op_t;

	localparam int unsigned OffsetWidth = 7;
	localparam int unsigned ColWidth    = 6;
	localparam int unsigned ExtraWidth  = 6;
	localparam int unsigned HoldWidth   = 8;
	localparam int unsigned PhaseWidth  = 3;
	localparam int unsigned IdxWidth    = 3;
	localparam int unsigned InDataWidth  = 16;
	localparam int unsigned OutDataWidth = 16;

	localparam logic [PhaseWidth-1:0] PHASE_LAST  = 3'd5;
	localparam logic [IdxWidth-1:0]   INIT_LAST   = 3'd6;
	localparam logic [HoldWidth-1:0]  POWER_HOLD  = 8'd150;
	localparam logic [7:0]            CURSOR_CMD  = 8'h80;
	localparam logic [ExtraWidth-1:0] EXTRA_CURSOR = 6'd1;
	localparam logic [OffsetWidth-1:0] OFFSET_RESET = 7'd64;

	typedef struct packed {
		logic [7:0]            byte_val;
		logic                  rs;
		logic [ExtraWidth-1:0] extra;
		logic [PhaseWidth-1:0] phase;
		logic                  pwr;
		logic                  last;
	} beat_ctl_t;

	function automatic logic [7:0] init_byte(input logic [IdxWidth-1:0] idx);
		logic [7:0] b;
		unique case (idx)
			3'd0:    b = 8'h33;
			3'd1:    b = 8'h32;
			3'd2:    b = 8'h28;
			3'd3:    b = 8'h0F;
			3'd4:    b = 8'h01;
			3'd5:    b = 8'h06;
			default: b = CURSOR_CMD;
		endcase
		return b;
	endfunction

	function automatic logic [ExtraWidth-1:0] init_extra(input logic [IdxWidth-1:0] idx);
		logic [ExtraWidth-1:0] e;
		unique case (idx)
			3'd0:    e = 6'd50;
			3'd4:    e = 6'd20;
			default: e = 6'd1;
		endcase
		return e;
	endfunction

endpackage

[hdl/char_lcd_nibble_sequencer_unit.sv]
// Expands one request on the slave stream into a run of LCD pin states on the
// master stream, one beat per pin state and one beat per cycle while the sink
// is ready. A command, data or set-cursor request gives 6 beats; initialise
// gives 43 beats (a power-up hold followed by seven command bytes). The input
// is not ready from acceptance until the cycle after the last beat of the run
// is taken, so requests do not overlap; a single beat formatting unit, stepped
// by a phase and byte counter, forms each beat.
module char_lcd_nibble_sequencer_unit
	import lcdns_pkg::*;
#(
	parameter logic [OffsetWidth-1:0] OffsetReset = OFFSET_RESET
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [OffsetWidth-1:0]  cfg_wdata,
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	// Fields from bit 0: byte_value, row, column, zero fill.
	input  logic [InDataWidth-1:0]  s_axis_tdata,
	// Fields from bit 0: opcode.
	input  logic [1:0]              s_axis_tuser,
	output logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	// Fields from bit 0: register_select, enable, data_nibble, hold_units, zero fill.
	output logic [OutDataWidth-1:0] m_axis_tdata,
	output logic                    m_axis_tlast
);

	logic [OffsetWidth-1:0] offset_q;
	beat_ctl_t              ctl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= OffsetReset;
		end else if (cfg_we) begin
			offset_q <= cfg_wdata;
		end
	end

	lcdns_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.offset    (offset_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_op     (op_t'(s_axis_tuser)),
		.in_byte   (s_axis_tdata[7:0]),
		.in_row    (s_axis_tdata[8]),
		.in_col    (s_axis_tdata[14:9]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.ctl       (ctl)
	);

	lcdns_beat_unit u_beat (
		.ctl   (ctl),
		.tdata (m_axis_tdata),
		.tlast (m_axis_tlast)
	);

endmodule

[hdl/lcdns_beat_unit.sv]
module lcdns_beat_unit
	import lcdns_pkg::*;
(
	input  beat_ctl_t                ctl,
	// Fields from bit 0: register_select, enable, data_nibble, hold_units, zero fill.
	output logic [OutDataWidth-1:0]  tdata,
	output logic                     tlast
);

	logic                  high_half;
	logic [1:0]            sub;
	logic [3:0]            nibble;
	logic                  en;
	logic [HoldWidth-1:0]  hold;
	logic [HoldWidth-1:0]  add;

	always_comb begin
		high_half = (ctl.phase < 3'd3);
		sub       = high_half ? ctl.phase[1:0] : 2'(ctl.phase - 3'd3);
		nibble    = high_half ? ctl.byte_val[7:4] : ctl.byte_val[3:0];
		en        = (sub == 2'd1);
		add       = (ctl.phase == PHASE_LAST) ? HoldWidth'(ctl.extra) : '0;
		if (ctl.pwr) begin
			hold = POWER_HOLD;
		end else begin
			hold = HoldWidth'(sub) + add;
		end
	end

	assign tdata = {2'b00, hold, (ctl.pwr ? 4'h0 : nibble), (en & ~ctl.pwr), (ctl.rs & ~ctl.pwr)};
	assign tlast = ctl.last;

endmodule

[hdl/lcdns_seq.sv]
module lcdns_seq
	import lcdns_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [OffsetWidth-1:0] offset,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  op_t                    in_op,
	input  logic [7:0]             in_byte,
	input  logic                   in_row,
	input  logic [ColWidth-1:0]    in_col,
	output logic                   out_valid,
	input  logic                   out_ready,
	output beat_ctl_t              ctl
);

	typedef enum logic {S_IDLE, S_RUN} state_t;

	state_t                state_q;
	logic [7:0]            byte_q;
	logic                  rs_q;
	logic [ExtraWidth-1:0] extra_q;
	logic [PhaseWidth-1:0] phase_q;
	logic [IdxWidth-1:0]   idx_q;
	logic                  init_q;
	logic                  pwr_q;

	logic                  last;
	logic [OffsetWidth-1:0] addr;
	logic [IdxWidth-1:0]   idx_next;

	assign addr     = OffsetWidth'(in_col) + (in_row ? offset : '0);
	assign idx_next = idx_q + 3'd1;
	assign last     = (phase_q == PHASE_LAST) && !pwr_q && (!init_q || idx_q == INIT_LAST);

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_RUN);
	assign ctl = '{byte_val: byte_q, rs: rs_q, extra: extra_q, phase: phase_q,
		pwr: pwr_q, last: last};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			byte_q  <= '0;
			rs_q    <= 1'b0;
			extra_q <= '0;
			phase_q <= '0;
			idx_q   <= '0;
			init_q  <= 1'b0;
			pwr_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_RUN;
						phase_q <= '0;
						idx_q   <= '0;
						pwr_q   <= 1'b0;
						init_q  <= 1'b0;
						rs_q    <= 1'b0;
						byte_q  <= in_byte;
						extra_q <= '0;
						unique case (in_op)
							OP_CMD: begin
							end
							OP_DATA: begin
								rs_q <= 1'b1;
							end
							OP_CURSOR: begin
								byte_q  <= CURSOR_CMD | {1'b0, addr};
								extra_q <= EXTRA_CURSOR;
							end
							OP_INIT: begin
								init_q  <= 1'b1;
								pwr_q   <= 1'b1;
								byte_q  <= init_byte('0);
								extra_q <= init_extra('0);
							end
						endcase
					end
				end
				S_RUN: begin
					if (out_ready) begin
						if (pwr_q) begin
							pwr_q <= 1'b0;
						end else if (last) begin
							state_q <= S_IDLE;
						end else if (phase_q == PHASE_LAST) begin
							phase_q <= '0;
							idx_q   <= idx_next;
							byte_q  <= init_byte(idx_next);
							extra_q <= init_extra(idx_next);
						end else begin
							phase_q <= phase_q + 3'd1;
						end
					end
				end
			endcase
		end
	end

endmodule

[verif/char_lcd_nibble_sequencer_unit_tb.sv]
`timescale 1ns / 100ps

module char_lcd_nibble_sequencer_unit_tb
	import lcdns_pkg::*;
();

	localparam int unsigned CycleLimit = 400000;

	typedef struct packed {
		logic       rs;
		logic       en;
		logic [3:0] nibble;
		logic [7:0] hold;
		logic       last;
	} pin_state_t;

	class lcd_pin_scoreboard;
		pin_state_t               pin_queue[$];
		logic [OffsetWidth-1:0]   row1_offset;
		int unsigned              mismatches;

		function new();
			pin_queue = {};
			row1_offset = OFFSET_RESET;
			mismatches = 0;
		endfunction

		function void set_offset(logic [OffsetWidth-1:0] value);
			row1_offset = value;
		endfunction

		function int unsigned pending();
			return pin_queue.size();
		endfunction

		function void push_state(logic rs, logic en, logic [3:0] nib, logic [7:0] hold);
			pin_state_t s;
			s.rs = rs;
			s.en = en;
			s.nibble = nib;
			s.hold = hold;
			s.last = 1'b0;
			pin_queue.push_back(s);
		endfunction

		function void push_byte(logic [7:0] value, logic rs, logic [7:0] extra);
			push_state(rs, 1'b0, value[7:4], 8'd0);
			push_state(rs, 1'b1, value[7:4], 8'd1);
			push_state(rs, 1'b0, value[7:4], 8'd2);
			push_state(rs, 1'b0, value[3:0], 8'd0);
			push_state(rs, 1'b1, value[3:0], 8'd1);
			push_state(rs, 1'b0, value[3:0], 8'd2 + extra);
		endfunction

		function void note_request(op_t op, logic [7:0] value, logic row, logic [5:0] column);
			logic [6:0] addr;
			pin_state_t s;
			case (op)
				OP_CMD: begin
					push_byte(value, 1'b0, 8'd0);
				end
				OP_DATA: begin
					push_byte(value, 1'b1, 8'd0);
				end
				OP_CURSOR: begin
					addr = 7'(column) + (row ? row1_offset : 7'd0);
					push_byte(8'h80 | {1'b0, addr}, 1'b0, 8'd1);
				end
				default: begin
					push_state(1'b0, 1'b0, 4'h0, 8'd150);
					push_byte(8'h33, 1'b0, 8'd50);
					push_byte(8'h32, 1'b0, 8'd1);
					push_byte(8'h28, 1'b0, 8'd1);
					push_byte(8'h0F, 1'b0, 8'd1);
					push_byte(8'h01, 1'b0, 8'd20);
					push_byte(8'h06, 1'b0, 8'd1);
					push_byte(8'h80, 1'b0, 8'd1);
				end
			endcase
			s = pin_queue[$];
			s.last = 1'b1;
			pin_queue[pin_queue.size() - 1] = s;
		endfunction

		function void check_beat(logic [OutDataWidth-1:0] data, logic tlast);
			pin_state_t want;
			pin_state_t got;
			got.rs = data[0];
			got.en = data[1];
			got.nibble = data[5:2];
			got.hold = data[13:6];
			got.last = tlast;
			if (pin_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected beat: rs %0d en %0d nibble %h hold %0d last %0d",
						got.rs, got.en, got.nibble, got.hold, got.last);
				return;
			end
			want = pin_queue.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("Beat mismatch: expected rs %0d en %0d nibble %h hold %0d last %0d",
						want.rs, want.en, want.nibble, want.hold, want.last);
					$display("  got rs %0d en %0d nibble %h hold %0d last %0d",
						got.rs, got.en, got.nibble, got.hold, got.last);
				end
			end
		endfunction
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic [OffsetWidth-1:0]  cfg_wdata;
	logic                    s_axis_tvalid;
	logic                    s_axis_tready;
	logic [InDataWidth-1:0]  s_axis_tdata;
	logic [1:0]              s_axis_tuser;
	logic                    m_axis_tvalid;
	logic                    m_axis_tready = 1'b0;
	logic [OutDataWidth-1:0] m_axis_tdata;
	logic                    m_axis_tlast;

	int unsigned             src_idle_pct;
	int unsigned             sink_stall_pct;
	int unsigned             cycle_count = 0;
	lcd_pin_scoreboard       sb;

	char_lcd_nibble_sequencer_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_beat(m_axis_tdata, m_axis_tlast);
		m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic send_request(op_t op, logic [7:0] value, logic row, logic [5:0] column);
		if ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {1'b0, column, row, value};
		s_axis_tuser  <= op;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_request(op, value, row, column);
	endtask

	task automatic wait_for_drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_offset(logic [OffsetWidth-1:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb.set_offset(value);
		@(posedge clk);
	endtask

	task automatic send_random();
		int unsigned pick;
		op_t op;
		pick = $urandom_range(99);
		if (pick < 30)
			op = OP_CMD;
		else if (pick < 60)
			op = OP_DATA;
		else if (pick < 90)
			op = OP_CURSOR;
		else
			op = OP_INIT;
		send_request(op, 8'($urandom), 1'($urandom), 6'($urandom_range(63)));
	endtask

	initial begin
		int unsigned idle_plan[4];
		int unsigned stall_plan[4];
		logic [OffsetWidth-1:0] offset_plan[4];

		idle_plan   = '{0, 62, 0, 30};
		stall_plan  = '{0, 0, 62, 30};
		offset_plan = '{7'd0, 7'd127, 7'($urandom), 7'($urandom)};

		sb = new();
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_wdata      = '0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		s_axis_tuser   = OP_CMD;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset offset first, then the cursor address at both extreme offsets, with the wrap at offset 127.
		send_request(OP_CMD, 8'h00, 1'b0, 6'd0);
		send_request(OP_CMD, 8'hFF, 1'b1, 6'd63);
		send_request(OP_DATA, 8'h00, 1'b0, 6'd0);
		send_request(OP_DATA, 8'hFF, 1'b1, 6'd63);
		send_request(OP_DATA, 8'hA5, 1'b0, 6'd21);
		send_request(OP_CMD, 8'h5A, 1'b1, 6'd42);
		send_request(OP_CURSOR, 8'hFF, 1'b0, 6'd0);
		send_request(OP_CURSOR, 8'h00, 1'b0, 6'd63);
		send_request(OP_CURSOR, 8'h00, 1'b1, 6'd0);
		send_request(OP_CURSOR, 8'hFF, 1'b1, 6'd63);
		send_request(OP_INIT, 8'hFF, 1'b1, 6'd63);
		send_request(OP_INIT, 8'h00, 1'b0, 6'd0);
		wait_for_drain();
		write_offset(7'd127);
		send_request(OP_CURSOR, 8'h00, 1'b1, 6'd63);
		send_request(OP_CURSOR, 8'h00, 1'b1, 6'd1);
		send_request(OP_CURSOR, 8'h00, 1'b0, 6'd63);
		send_request(OP_INIT, 8'h3C, 1'b1, 6'd17);
		wait_for_drain();
		write_offset(7'd0);
		send_request(OP_CURSOR, 8'h00, 1'b1, 6'd63);
		send_request(OP_CURSOR, 8'h00, 1'b1, 6'd5);
		wait_for_drain();

		for (int p = 0; p < 4; p++) begin
			write_offset(offset_plan[p]);
			src_idle_pct   = idle_plan[p];
			sink_stall_pct = stall_plan[p];
			for (int n = 0; n < 21; n++) begin
				send_random();
				if (p == 2 && n == 12)
					wait_for_drain();
			end
			wait_for_drain();
		end

		src_idle_pct   = 0;
		sink_stall_pct = 0;
		repeat (10) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
